// File: design/assert_macros.svh
// Assertion macros used by the audio gain and echo unit.
// Depends on nothing; each macro expands to one concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A condition that must be followed by another in the next cycle.
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// File: design/age_pkg.sv
// Package for the audio gain and echo unit: beat types, register codes and defaults.
// Depends on nothing; used by audio_gain_echo_unit.
`default_nettype none

package age_pkg;

   localparam int DELAY_DEPTH_DEFAULT = 65536;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 16;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_EFFECT_SELECT = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GAIN          = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ECHO_DELAY    = 2'd2;

   localparam int SEL_VOLUME_BIT = 0;
   localparam int SEL_ECHO_BIT   = 1;

   localparam logic [1:0]  EFFECT_SELECT_RESET = 2'd0;
   localparam logic [15:0] GAIN_RESET          = 16'd256;
   localparam logic [15:0] ECHO_DELAY_RESET    = 16'd32768;

   typedef struct packed {
      logic signed [15:0] sample_in;
      logic               block_end_in;
   } req_type;

   typedef struct packed {
      logic signed [15:0] sample_out;
      logic               block_end_out;
   } rsp_type;

endpackage

`default_nettype wire

// File: design/audio_gain_echo_unit.sv
// Top level of the audio gain and echo unit: gain multiply, delay line memory, output register.
// Depends on age_pkg and assert_macros.svh.
//
// Usage:
// Samples enter on the req_ channel (valid/stall) and leave on the rsp_ channel, one
// result beat for each request beat, in order. The unit applies an unsigned Q8.8 gain
// with truncation toward zero and saturation, then optionally adds the dry value stored
// echo_delay samples earlier in a delay line memory, again with saturation.
// An accepted request beat passes the middle stage, then the output register, to rsp_valid.
// Throughput is one sample per cycle while rsp_stall is low. Each sample costs one read of
// the delay line memory, plus one write with echo on; a same-cycle write hit is forwarded.
// When rsp_stall is high the output register holds its beat; the middle stage keeps
// accepting into any empty slot, and req_stall rises once both stages are full.
// Reset is synchronous and active high. It restores the register defaults and empties
// the pipeline. The delay line itself is not swept: a fill count records how many
// entries have been written since reset, and an unwritten entry reads as zero, so
// the unit takes requests in the first cycle after reset.
// Registers are written through csr_write_enable, csr_index and csr_write_data; the user
// must write them only while no beat is in flight, as the block does not enforce this.
`default_nettype none
`include "assert_macros.svh"

module audio_gain_echo_unit #(
   parameter int DELAY_DEPTH = age_pkg::DELAY_DEPTH_DEFAULT
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  wire  age_pkg::req_type                req_payload,
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output age_pkg::rsp_type                      rsp_payload,
   input  wire                                   csr_write_enable,
   input  wire  [age_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  wire  [age_pkg::CSR_DATA_WIDTH-1:0]    csr_write_data
);

   localparam int AW = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
   localparam int FW = AW + 1;
   localparam int CW = (FW > 17) ? FW : 17;
   localparam logic [CW-1:0] DEPTH_C = CW'(DELAY_DEPTH);
   localparam logic [FW-1:0] DEPTH_F = FW'(DELAY_DEPTH);
   localparam logic [AW-1:0] LAST_ADDR = AW'(DELAY_DEPTH - 1);

   logic [1:0]  effect_ff, effect_in;
   logic [15:0] gain_ff, gain_in;
   logic [15:0] delay_ff, delay_in;

   logic [AW-1:0] wp_ff, wp_in;
   logic [FW-1:0] fill_ff, fill_in;

   logic               s1_valid_ff, s1_valid_in;
   logic signed [32:0] s1_prod_ff;
   logic signed [15:0] s1_sample_ff;
   logic               s1_block_ff;
   logic               s1_vol_ff;
   logic               s1_echo_ff;
   logic [AW-1:0]      s1_wp_ff;
   logic               s1_fwd_ff;
   logic               s1_old_ok_ff;
   logic signed [15:0] s1_fwd_data_ff;
   logic signed [15:0] rd_data_ff;

   logic             rsp_valid_ff, rsp_valid_in;
   age_pkg::rsp_type rsp_payload_ff;

   logic signed [15:0] mem [DELAY_DEPTH];

   logic               req_accept;
   logic               out_ready;
   logic               s1_adv;
   logic               mem_we;
   logic               echo_now;
   logic signed [32:0] prod_in;
   logic [CW-1:0]      d_ext;
   logic [CW-1:0]      d_clamp;
   logic [CW-1:0]      wp_ext;
   logic [CW-1:0]      rp_ext;
   logic [AW-1:0]      rp;
   logic               fwd_in;
   logic               old_ok_in;
   logic signed [32:0] biased;
   logic signed [24:0] shifted;
   logic signed [15:0] gained;
   logic signed [15:0] dry;
   logic signed [15:0] old;
   logic signed [16:0] sum;
   logic signed [15:0] wet;

   assign out_ready  = !rsp_valid_ff || !rsp_stall;
   assign s1_adv     = s1_valid_ff && out_ready;
   assign req_stall  = s1_valid_ff && !out_ready;
   assign req_accept = req_valid && !req_stall;
   assign mem_we     = s1_adv && s1_echo_ff;
   assign echo_now   = effect_ff[age_pkg::SEL_ECHO_BIT];

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   assign prod_in = $signed({{17{req_payload.sample_in[15]}}, req_payload.sample_in})
                  * $signed({17'b0, gain_ff});

   always_comb begin
      d_ext = CW'(delay_ff);
      if (d_ext == '0) begin
         d_clamp = CW'(1);
      end else if (d_ext >= DEPTH_C) begin
         d_clamp = DEPTH_C - CW'(1);
      end else begin
         d_clamp = d_ext;
      end
      wp_ext = CW'(wp_ff);
      if (wp_ext >= d_clamp) begin
         rp_ext = wp_ext - d_clamp;
      end else begin
         rp_ext = wp_ext + DEPTH_C - d_clamp;
      end
      rp = rp_ext[AW-1:0];
      fwd_in    = mem_we && (rp == s1_wp_ff);
      old_ok_in = (fill_ff == DEPTH_F) || ({1'b0, rp} < fill_ff);
   end

   always_comb begin
      biased  = s1_prod_ff + (s1_prod_ff[32] ? 33'sd255 : 33'sd0);
      shifted = biased[32:8];
      if (!shifted[24] && (|shifted[23:15])) begin
         gained = 16'sh7FFF;
      end else if (shifted[24] && !(&shifted[23:15])) begin
         gained = -16'sh8000;
      end else begin
         gained = shifted[15:0];
      end
      dry = s1_vol_ff ? gained : s1_sample_ff;
      if (s1_fwd_ff) begin
         old = s1_fwd_data_ff;
      end else if (s1_old_ok_ff) begin
         old = rd_data_ff;
      end else begin
         old = '0;
      end
      sum = {dry[15], dry} + {old[15], old};
      if (sum[16] != sum[15]) begin
         wet = sum[16] ? -16'sh8000 : 16'sh7FFF;
      end else begin
         wet = sum[15:0];
      end
   end

   always_comb begin
      effect_in = effect_ff;
      gain_in   = gain_ff;
      delay_in  = delay_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            age_pkg::CSR_EFFECT_SELECT: effect_in = csr_write_data[1:0];
            age_pkg::CSR_GAIN:          gain_in   = csr_write_data;
            age_pkg::CSR_ECHO_DELAY:    delay_in  = csr_write_data;
            default: ;
         endcase
      end
      wp_in = wp_ff;
      if (req_accept && echo_now) begin
         wp_in = (wp_ff == LAST_ADDR) ? '0 : wp_ff + AW'(1);
      end
      fill_in = fill_ff;
      if (mem_we && (fill_ff != DEPTH_F)) begin
         fill_in = fill_ff + FW'(1);
      end
      s1_valid_in  = req_accept || (s1_valid_ff && !s1_adv);
      rsp_valid_in = s1_adv || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         effect_ff    <= age_pkg::EFFECT_SELECT_RESET;
         gain_ff      <= age_pkg::GAIN_RESET;
         delay_ff     <= age_pkg::ECHO_DELAY_RESET;
         wp_ff        <= '0;
         fill_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         effect_ff    <= effect_in;
         gain_ff      <= gain_in;
         delay_ff     <= delay_in;
         wp_ff        <= wp_in;
         fill_ff      <= fill_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_prod_ff     <= prod_in;
         s1_sample_ff   <= req_payload.sample_in;
         s1_block_ff    <= req_payload.block_end_in;
         s1_vol_ff      <= effect_ff[age_pkg::SEL_VOLUME_BIT];
         s1_echo_ff     <= echo_now;
         s1_wp_ff       <= wp_ff;
         s1_fwd_ff      <= fwd_in;
         s1_old_ok_ff   <= old_ok_in;
         s1_fwd_data_ff <= dry;
      end
      if (s1_adv) begin
         rsp_payload_ff.sample_out    <= s1_echo_ff ? wet : dry;
         rsp_payload_ff.block_end_out <= s1_block_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rd_data_ff <= mem[rp];
      end
      if (mem_we) begin
         mem[s1_wp_ff] <= dry;
      end
   end

   `ASSERT_NEXT(a_accept_fills_stage, clock, reset, req_accept, s1_valid_ff, "accepted beat lost")
   `ASSERT_NEXT(a_hold, clock, reset, req_stall, $stable({s1_valid_ff, s1_wp_ff}), "stage moved")
   `ASSERT_ALWAYS(a_fill_bounded, clock, reset, fill_ff <= DEPTH_F, "fill count beyond depth")

endmodule

`default_nettype wire
